// ----- sv/lmsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types and constants of the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  // Default matrix geometry
  localparam int unsigned RowCountDef    = 7;
  localparam int unsigned ColumnCountDef = 9;

  // Stream field widths
  localparam int unsigned AddrW    = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 16;  // frame_addr + frame_value, padded
  localparam int unsigned PinCount = 5;
  localparam int unsigned OutDataW = 8;   // five pin levels, padded

  // Request kind carried on the input tuser line
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // Pin positions inside the pin level vector
  localparam int unsigned PinColData  = 0;
  localparam int unsigned PinColClock = 1;
  localparam int unsigned PinRowData  = 2;
  localparam int unsigned PinRowClock = 3;
  localparam int unsigned PinLatch    = 4;

  localparam logic [ByteW-1:0] ByteInvert = 8'hFF;

  // Scan segment within one column slot
  typedef enum logic [1:0] {
    SEG_COL_BYTE,
    SEG_ROW_BYTE,
    SEG_LATCH_HIGH,
    SEG_LATCH_LOW
  } seg_e;

  // Pin operation performed by one tick
  typedef enum logic [2:0] {
    OP_COL_SET,
    OP_COL_RISE,
    OP_ROW_SET,
    OP_ROW_RISE,
    OP_LATCH_HIGH,
    OP_LATCH_LOW
  } op_e;

  // Tick control handed from the sequencer stage to the pin stage
  typedef struct packed {
    op_e              op;
    logic             cap_store;  // take the byte read from the frame store
    logic             cap_row;    // take the row select byte
    logic [ByteW-1:0] row_byte;
    logic [2:0]       shift;      // bit of the held byte to put on data
  } tick_ctrl_t;

endpackage

// ----- sv/lmsd_frame_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_frame_store
// Frame byte memory, one write and one registered read per cycle. Entries
// carry valid bits so that unwritten entries and reads beyond the store
// return zero right after reset.
// ----------------------------------------------------------------------------
module lmsd_frame_store #(
  parameter int unsigned Depth = 63,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [lmsd_pkg::ByteW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [lmsd_pkg::ByteW-1:0] rd_data_o
);

  localparam int unsigned MW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [lmsd_pkg::ByteW-1:0] mem [Depth];
  logic [Depth-1:0]           vld_q;
  logic [lmsd_pkg::ByteW-1:0] rd_q;
  logic                       rd_ok_q;
  logic                       wr_hit;
  logic                       rd_hit;
  logic [MW-1:0]              wr_idx;
  logic [MW-1:0]              rd_idx;

  // Drop accesses beyond the store
  assign wr_hit = wr_en_i && (wr_addr_i < AW'(Depth));
  assign rd_hit = rd_addr_i < AW'(Depth);
  assign wr_idx = wr_addr_i[MW-1:0];
  assign rd_idx = rd_addr_i[MW-1:0];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[wr_idx] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i && rd_hit) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Mark written entries, qualify the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= rd_hit && vld_q[rd_idx];
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

// ----- sv/led_matrix_scan_driver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scan_driver_core
// Multiplexed LED matrix refresh: frame byte store plus scan sequencer that
// produces one five-pin snapshot per tick request.
// ----------------------------------------------------------------------------
// Requests enter one per clock while s_axis_tready_o is high. A write request
// (tuser low) stores one frame byte and produces no output; a tick request
// (tuser high) produces exactly one pin snapshot: the accepting edge updates
// the scan counters, registers the frame store read and the tick control, and
// the pin stage then forms the pin levels in the output register.
// With the output side ready the block sustains one request per clock, as the
// input takes one request at a time. The store comes out of reset reading all
// zero at once through per-entry valid bits, so no clearing pass is needed.
// Snapshot bits from the lowest up: column data, column clock, row data, row
// clock, latch.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_core #(
  parameter int unsigned RowCount    = lmsd_pkg::RowCountDef,
  parameter int unsigned ColumnCount = lmsd_pkg::ColumnCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [5:0] frame_addr, [13:6] frame_value, [15:14] zero
  input  logic [lmsd_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] func
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] col_data, [1] col_clock, [2] row_data, [3] row_clock,
  // [4] latch_level, [7:5] zero
  output logic [lmsd_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned StoreSize  = RowCount * ColumnCount;
  localparam int unsigned GroupCount = (ColumnCount + 2) / 3;
  localparam int unsigned RW = (RowCount > 1) ? $clog2(RowCount) : 1;
  localparam int unsigned GW = (GroupCount > 1) ? $clog2(GroupCount) : 1;
  localparam int unsigned SpanW = $clog2(3 * GroupCount * RowCount);
  localparam int unsigned IW = (SpanW > lmsd_pkg::AddrW) ? SpanW : lmsd_pkg::AddrW;
  localparam int unsigned CW = $clog2(ColumnCount);

  // Scan counters
  lmsd_pkg::seg_e   seg_q, seg_d;
  logic [2:0]       bit_q, bit_d;
  logic             half_q, half_d;
  logic [RW-1:0]    row_q, row_d;
  logic [GW-1:0]    grp_q, grp_d;
  logic [1:0]       plc_q, plc_d;

  // Pin stage
  logic                         s1_valid_q;
  lmsd_pkg::tick_ctrl_t         s1_ctrl_q;
  lmsd_pkg::tick_ctrl_t         ctrl_s0;
  logic                         out_valid_q;
  logic [lmsd_pkg::PinCount-1:0] pins_q, pins_d;
  logic [lmsd_pkg::ByteW-1:0]   held_q, held_d;
  logic [lmsd_pkg::ByteW-1:0]   store_rdata;
  logic [lmsd_pkg::ByteW-1:0]   cur_byte;

  logic          in_fire, tick_fire, wr_fire, out_ready, s1_adv;
  logic          shift_start, col_last;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] pos;
  logic [CW-1:0] col_idx;

  // Handshake: take a request whenever the pin stage can move on
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_ready;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign tick_fire       = in_fire && (s_axis_tuser_i == lmsd_pkg::FuncTick);
  assign wr_fire         = in_fire && (s_axis_tuser_i == lmsd_pkg::FuncWrite);

  assign shift_start = (bit_q == 3'd0) && !half_q;
  assign col_idx     = CW'(grp_q) * CW'(3) + CW'(plc_q);
  assign col_last    = col_idx == CW'(ColumnCount - 1);

  // Column slot order inside a group of three is reversed
  assign pos    = IW'(grp_q) * IW'(3) + IW'(2) - IW'(plc_q);
  assign rd_idx = pos * IW'(RowCount) + IW'(row_q);

  // Next scan state
  always_comb begin
    seg_d  = seg_q;
    bit_d  = bit_q;
    half_d = half_q;
    row_d  = row_q;
    grp_d  = grp_q;
    plc_d  = plc_q;
    unique case (seg_q)
      lmsd_pkg::SEG_COL_BYTE, lmsd_pkg::SEG_ROW_BYTE: begin
        half_d = !half_q;
        if (half_q) begin
          bit_d = bit_q + 3'd1;
        end
      end
      default: ;
    endcase
    priority if (seg_q == lmsd_pkg::SEG_COL_BYTE && half_q && bit_q == 3'd7 &&
                 plc_q == 2'd2) begin
      seg_d = lmsd_pkg::SEG_ROW_BYTE;
    end else if ((seg_q == lmsd_pkg::SEG_COL_BYTE && half_q && bit_q == 3'd7) ||
                 seg_q == lmsd_pkg::SEG_LATCH_LOW) begin
      // Advance to the next column, wrapping into the next row
      seg_d = lmsd_pkg::SEG_COL_BYTE;
      if (col_last) begin
        plc_d = 2'd0;
        grp_d = '0;
        row_d = (row_q == RW'(RowCount - 1)) ? '0 : row_q + RW'(1);
      end else if (plc_q == 2'd2) begin
        plc_d = 2'd0;
        grp_d = grp_q + GW'(1);
      end else begin
        plc_d = plc_q + 2'd1;
      end
    end else if (seg_q == lmsd_pkg::SEG_ROW_BYTE && half_q && bit_q == 3'd7) begin
      seg_d = lmsd_pkg::SEG_LATCH_HIGH;
    end else if (seg_q == lmsd_pkg::SEG_LATCH_HIGH) begin
      seg_d = lmsd_pkg::SEG_LATCH_LOW;
    end else begin
      seg_d = seg_q;
    end
  end

  // Tick control for the pin stage
  always_comb begin
    ctrl_s0.cap_store = 1'b0;
    ctrl_s0.cap_row   = 1'b0;
    ctrl_s0.row_byte  = lmsd_pkg::ByteW'(row_q) + (lmsd_pkg::ByteW'(grp_q) << 3);
    ctrl_s0.shift     = bit_q;
    unique case (seg_q)
      lmsd_pkg::SEG_COL_BYTE: begin
        ctrl_s0.op        = half_q ? lmsd_pkg::OP_COL_RISE : lmsd_pkg::OP_COL_SET;
        ctrl_s0.cap_store = shift_start;
      end
      lmsd_pkg::SEG_ROW_BYTE: begin
        ctrl_s0.op      = half_q ? lmsd_pkg::OP_ROW_RISE : lmsd_pkg::OP_ROW_SET;
        ctrl_s0.cap_row = shift_start;
        ctrl_s0.shift   = 3'd7 - bit_q;
      end
      lmsd_pkg::SEG_LATCH_HIGH: ctrl_s0.op = lmsd_pkg::OP_LATCH_HIGH;
      lmsd_pkg::SEG_LATCH_LOW:  ctrl_s0.op = lmsd_pkg::OP_LATCH_LOW;
      default:                  ctrl_s0.op = lmsd_pkg::OP_LATCH_LOW;
    endcase
  end

  // Scan counters advance on each tick request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= lmsd_pkg::SEG_COL_BYTE;
      bit_q  <= 3'd0;
      half_q <= 1'b0;
      row_q  <= '0;
      grp_q  <= '0;
      plc_q  <= 2'd0;
    end else if (tick_fire) begin
      seg_q  <= seg_d;
      bit_q  <= bit_d;
      half_q <= half_d;
      row_q  <= row_d;
      grp_q  <= grp_d;
      plc_q  <= plc_d;
    end
  end

  lmsd_frame_store #(
    .Depth (StoreSize),
    .AW    (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_fire),
    .wr_addr_i (IW'(s_axis_tdata_i[lmsd_pkg::AddrW-1:0])),
    .wr_data_i (s_axis_tdata_i[lmsd_pkg::AddrW +: lmsd_pkg::ByteW]),
    .rd_en_i   (tick_fire && ctrl_s0.cap_store),
    .rd_addr_i (rd_idx),
    .rd_data_o (store_rdata)
  );

  // Pick the byte being shifted, then apply the pin operation
  always_comb begin
    priority if (s1_ctrl_q.cap_store) begin
      cur_byte = store_rdata ^ lmsd_pkg::ByteInvert;
    end else if (s1_ctrl_q.cap_row) begin
      cur_byte = s1_ctrl_q.row_byte;
    end else begin
      cur_byte = held_q;
    end
    held_d = cur_byte;
    pins_d = pins_q;
    unique case (s1_ctrl_q.op)
      lmsd_pkg::OP_COL_SET: begin
        pins_d[lmsd_pkg::PinColClock] = 1'b0;
        pins_d[lmsd_pkg::PinColData]  = cur_byte[s1_ctrl_q.shift];
      end
      lmsd_pkg::OP_COL_RISE: pins_d[lmsd_pkg::PinColClock] = 1'b1;
      lmsd_pkg::OP_ROW_SET: begin
        pins_d[lmsd_pkg::PinRowClock] = 1'b0;
        pins_d[lmsd_pkg::PinRowData]  = cur_byte[s1_ctrl_q.shift];
      end
      lmsd_pkg::OP_ROW_RISE:   pins_d[lmsd_pkg::PinRowClock] = 1'b1;
      lmsd_pkg::OP_LATCH_HIGH: pins_d[lmsd_pkg::PinLatch] = 1'b1;
      lmsd_pkg::OP_LATCH_LOW:  pins_d[lmsd_pkg::PinLatch] = 1'b0;
      default:                 pins_d = pins_q;
    endcase
  end

  // Hold the tick control while its store read is in flight
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s1_ctrl_q <= ctrl_s0;
    end
  end

  // Pin stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pins_q      <= '0;
      held_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= tick_fire;
      end
      if (s1_adv) begin
        pins_q      <= pins_d;
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = lmsd_pkg::OutDataW'(pins_q);

  // Latch segments only start on a byte boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q == lmsd_pkg::SEG_LATCH_HIGH || seg_q == lmsd_pkg::SEG_LATCH_LOW) |->
      (bit_q == 3'd0 && !half_q))
    else $error("latch segment entered mid byte");

  // Scan position stays inside the matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plc_q != 2'd3) && (col_idx <= CW'(ColumnCount - 1)) &&
      (row_q <= RW'(RowCount - 1)))
    else $error("scan position out of range");

  // Input stalls only when both stages are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without cause");

  // A stalled snapshot keeps its pins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(pins_q))
    else $error("pending snapshot changed");

endmodule
